// ----- sv/tkmt_pkg.sv -----
// Shared widths, constants and helpers for the top-k magnitude threshold block.
`default_nettype none
package tkmt_pkg;

  localparam int unsigned SCORE_W        = 32;
  localparam int unsigned CFG_W          = 9;
  localparam int unsigned HEAP_DEPTH_DEF = 256;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic        [CFG_W-1:0]   cfg_t;

  localparam score_t MOST_NEG = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam score_t MOST_POS = {1'b0, {(SCORE_W-1){1'b1}}};

  function automatic score_t magnitude(input score_t v);
    score_t m;
    if (v == MOST_NEG) begin
      m = MOST_POS;
    end else if (v < 0) begin
      m = -v;
    end else begin
      m = v;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- sv/tkmt_intf.sv -----
// Handshake channel interfaces for scores, thresholds and configuration.
`default_nettype none
interface tkmt_score_if;
  logic            valid;
  logic            ready;
  tkmt_pkg::score_t score_value;
  logic            last_score;
  modport source (output valid, output score_value, output last_score, input ready);
  modport sink   (input valid, input score_value, input last_score, output ready);
endinterface

interface tkmt_thr_if;
  logic            valid;
  logic            ready;
  tkmt_pkg::score_t threshold_value;
  modport source (output valid, output threshold_value, input ready);
  modport sink   (input valid, input threshold_value, output ready);
endinterface

interface tkmt_cfg_if;
  logic          valid;
  logic          ready;
  tkmt_pkg::cfg_t heap_entries;
  modport source (output valid, output heap_entries, input ready);
  modport sink   (input valid, input heap_entries, output ready);
endinterface
`default_nettype wire

// ----- sv/tkmt_heap_ram.sv -----
// Heap storage: one write port and two registered read ports.
`default_nettype none
module tkmt_heap_ram #(
  parameter int unsigned Depth = tkmt_pkg::HEAP_DEPTH_DEF,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic [AW-1:0]    rd_a_addr_i,
  input  wire logic [AW-1:0]    rd_b_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire tkmt_pkg::score_t wr_data_i,
  output tkmt_pkg::score_t      rd_a_data_o,
  output tkmt_pkg::score_t      rd_b_data_o
);

  tkmt_pkg::score_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_data_o <= mem[rd_a_addr_i];
    rd_b_data_o <= mem[rd_b_addr_i];
  end

endmodule
`default_nettype wire

// ----- sv/top_k_magnitude_threshold_top.sv -----
// Top level: keeps the K largest score magnitudes in a min-heap, emits the root on last.
//
//   channel   dir  word                          handshake
//   score_i   in   score_value, last_score       valid/ready
//   thr_o     out  threshold_value               valid/ready
//   cfg_i     in   heap_entries                  valid/ready (ready always high)
//
// A score is compared with the root and, if larger, sifted down from it with one
// compare-and-write per heap level walked, at most ceil(log2(K+1)) levels.
// After reset, after each last word and after each cfg write, a clearing pass writes the
// K active entries, one per cycle, with score_i not ready.
// A finished threshold waits in an output register; the next last word stalls only if
// that register is still full.
`default_nettype none
module top_k_magnitude_threshold_top #(
  parameter int unsigned HeapDepth = tkmt_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tkmt_score_if.sink     score_i,
  tkmt_thr_if.source     thr_o,
  tkmt_cfg_if.sink       cfg_i
);

  localparam int unsigned AW = (HeapDepth > 1) ? $clog2(HeapDepth) : 1;
  localparam int unsigned KW = $clog2(HeapDepth + 1);
  localparam int unsigned CW = AW + 2;

  typedef enum logic [2:0] {ST_IDLE, ST_ROOT, ST_SIFT, ST_FIN, ST_CLEAR} state_e;

  state_e           state_q;
  logic [AW-1:0]    pos_q;
  tkmt_pkg::score_t cur_q;
  tkmt_pkg::score_t root_q;
  tkmt_pkg::score_t out_q;
  logic             out_valid_q;
  logic             last_q;
  logic [KW-1:0]    kact_q;
  logic [KW-1:0]    clr_q;

  tkmt_pkg::score_t rda, rdb, wr_data, cval;
  logic [AW-1:0]    rd_a_addr, rd_b_addr, wr_addr, nxt_pos;
  logic             wr_en;
  logic [CW-1:0]    child, child_r, k_ext, c_idx;
  logic             has_child, has_right, pick_right, sift_stop;
  logic [KW-1:0]    cfg_k;
  logic             in_acc, cfg_acc;

  assign in_acc  = score_i.valid && score_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  assign score_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign thr_o.valid         = out_valid_q;
  assign thr_o.threshold_value = out_q;

  always_comb begin
    if (cfg_i.heap_entries == '0) begin
      cfg_k = KW'(1);
    end else if (32'(cfg_i.heap_entries) > 32'(HeapDepth)) begin
      cfg_k = KW'(HeapDepth);
    end else begin
      cfg_k = KW'(cfg_i.heap_entries);
    end
  end

  assign child      = (CW'(pos_q) << 1) | CW'(1);
  assign child_r    = child + CW'(1);
  assign k_ext      = CW'(kact_q);
  assign has_child  = child < k_ext;
  assign has_right  = child_r < k_ext;
  assign pick_right = has_right && (rdb < rda);
  assign cval       = pick_right ? rdb : rda;
  assign c_idx      = pick_right ? child_r : child;
  assign sift_stop  = !has_child || (cur_q <= cval);

  always_comb begin
    nxt_pos = (state_q == ST_SIFT) ? c_idx[AW-1:0] : '0;
    if (state_q == ST_IDLE) begin
      rd_a_addr = '0;
      rd_b_addr = '0;
    end else begin
      rd_a_addr = AW'({nxt_pos, 1'b1});
      rd_b_addr = AW'({nxt_pos, 1'b1} + (AW + 1)'(1));
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = sift_stop ? cur_q : cval;
    unique case (state_q)
      ST_SIFT: begin
        wr_en = 1'b1;
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q[AW-1:0];
        wr_data = tkmt_pkg::MOST_NEG;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  tkmt_heap_ram #(.Depth(HeapDepth)) u_ram (
    .clk_i       (clk_i),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_a_data_o (rda),
    .rd_b_data_o (rdb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      kact_q      <= KW'(1);
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      pos_q       <= '0;
      cur_q       <= tkmt_pkg::MOST_NEG;
      root_q      <= tkmt_pkg::MOST_NEG;
      out_q       <= tkmt_pkg::MOST_NEG;
    end else begin
      if (out_valid_q && thr_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cur_q   <= tkmt_pkg::magnitude(score_i.score_value);
            last_q  <= score_i.last_score;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (rda < cur_q) begin
            pos_q   <= '0;
            state_q <= ST_SIFT;
          end else begin
            root_q  <= rda;
            state_q <= ST_FIN;
          end
        end
        ST_SIFT: begin
          if (pos_q == '0) begin
            root_q <= wr_data;
          end
          if (sift_stop) begin
            state_q <= ST_FIN;
          end else begin
            pos_q <= c_idx[AW-1:0];
          end
        end
        ST_FIN: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (!out_valid_q || thr_o.ready) begin
            out_q       <= root_q;
            out_valid_q <= 1'b1;
            clr_q       <= '0;
            state_q     <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          if (clr_q + KW'(1) == kact_q) begin
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + KW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cfg_acc) begin
        kact_q  <= cfg_k;
        clr_q   <= '0;
        state_q <= ST_CLEAR;
      end
    end
  end

  a_accept_to_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !cfg_acc |=> state_q == ST_ROOT)
    else $error("accepted score did not start a root compare");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> CW'(wr_addr) < k_ext)
    else $error("heap write beyond active entries");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN) && $past(last_q))
    else $error("threshold loaded outside a last word");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && last_q && out_valid_q && !thr_o.ready && !cfg_acc
    |=> state_q == ST_FIN && $stable(out_q))
    else $error("pending threshold overwritten");

endmodule
`default_nettype wire
